### src/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 9;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam logic [7:0] HDR_BYTE  = 8'hAA;
    localparam logic [7:0] TAIL_BYTE = 8'h55;

    // configuration
    localparam int ADDR_W = 2;
    localparam logic [ADDR_W-1:0] ADDR_LINK_TIMEOUT = '0;
    localparam logic [15:0] LINK_TIMEOUT_RESET = 16'd300;

    // stream widths
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CHECK = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // one input transfer
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       last;
    } item_t;

    // command fields of the last good frame
    typedef struct packed {
        logic [7:0]        body_height;
        logic signed [7:0] turn_rate;
        logic signed [7:0] velocity_y;
        logic signed [7:0] velocity_x;
        logic [7:0]        gait_switch;
        logic [7:0]        mode_switch;
    } fields_t;

    // one result, first member in the highest bits so frame_accepted lands at bit 0
    typedef struct packed {
        logic [15:0] good_frame_count;
        logic        link_active;
        fields_t     fields;
        logic        checksum_error;
        logic        frame_accepted;
    } result_t;

    localparam int RESULT_W   = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

### src/cfr_core.sv
`default_nettype none

module cfr_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire cfr_pkg::item_t   item,
    input  wire logic [15:0]      link_timeout,
    output cfr_pkg::result_t      result
);

    logic [7:0]                  window_reg [cfr_pkg::FRAME_BYTES];
    logic [cfr_pkg::CNT_W-1:0]   count_reg, count_next;
    logic                        done_reg, done_next;
    logic [31:0]                 time_reg, time_next;
    logic [31:0]                 last_good_reg, last_good_next;
    logic                        link_reg, link_next;
    logic [15:0]                 good_cnt_reg, good_cnt_next;
    cfr_pkg::fields_t            latch_reg, latch_next;

    logic [7:0]  sum;
    logic [31:0] elapsed;
    logic        hit;
    logic        good;
    logic        bad;

    // frame detection, checksum and link supervision
    always_comb
    begin
        sum = '0;
        for (int k = 1; k <= cfr_pkg::FRAME_BYTES - 2; k++)
        begin
            sum = sum + window_reg[k];
        end

        // window after the shift: header is today's byte 1, tail is the new byte
        hit = (item.op == cfr_pkg::OP_BYTE) && !done_reg
              && (count_reg >= cfr_pkg::CNT_W'(cfr_pkg::FRAME_BYTES - 1))
              && (window_reg[1] == cfr_pkg::HDR_BYTE)
              && (item.data == cfr_pkg::TAIL_BYTE);
        good = hit && (sum == window_reg[cfr_pkg::FRAME_BYTES - 1]);
        bad  = hit && !good;

        elapsed = time_reg - last_good_reg;

        count_next     = count_reg;
        done_next      = done_reg;
        time_next      = time_reg;
        last_good_next = last_good_reg;
        link_next      = link_reg;
        good_cnt_next  = good_cnt_reg;
        latch_next     = latch_reg;

        case (item.op)
            cfr_pkg::OP_BYTE:
            begin
                if (count_reg < cfr_pkg::CNT_W'(cfr_pkg::FRAME_BYTES))
                begin
                    count_next = count_reg + 1'b1;
                end
                if (hit)
                begin
                    done_next = 1'b1;
                end
                if (good)
                begin
                    latch_next.mode_switch = window_reg[2];
                    latch_next.gait_switch = window_reg[3];
                    latch_next.velocity_x  = window_reg[4];
                    latch_next.velocity_y  = window_reg[5];
                    latch_next.turn_rate   = window_reg[6];
                    latch_next.body_height = window_reg[7];
                    last_good_next = time_reg;
                    link_next      = 1'b1;
                    good_cnt_next  = good_cnt_reg + 1'b1;
                end
                if (item.last)
                begin
                    count_next = '0;
                    done_next  = 1'b0;
                end
            end
            cfr_pkg::OP_TICK:
            begin
                time_next = time_reg + 1'b1;
            end
            cfr_pkg::OP_CHECK:
            begin
                if (link_reg && (elapsed > {16'd0, link_timeout}))
                begin
                    link_next     = 1'b0;
                    good_cnt_next = '0;
                end
            end
            default:
            begin
            end
        endcase

        result.frame_accepted   = good;
        result.checksum_error   = bad;
        result.fields           = latch_next;
        result.link_active      = link_next;
        result.good_frame_count = good_cnt_next;
    end

    // state update on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < cfr_pkg::FRAME_BYTES; k++)
            begin
                window_reg[k] <= '0;
            end
            count_reg     <= '0;
            done_reg      <= 1'b0;
            time_reg      <= '0;
            last_good_reg <= '0;
            link_reg      <= 1'b0;
            good_cnt_reg  <= '0;
            latch_reg     <= '0;
        end
        else if (accept)
        begin
            if (item.op == cfr_pkg::OP_BYTE)
            begin
                for (int k = 0; k < cfr_pkg::FRAME_BYTES - 1; k++)
                begin
                    window_reg[k] <= window_reg[k + 1];
                end
                window_reg[cfr_pkg::FRAME_BYTES - 1] <= item.data;
            end
            count_reg     <= count_next;
            done_reg      <= done_next;
            time_reg      <= time_next;
            last_good_reg <= last_good_next;
            link_reg      <= link_next;
            good_cnt_reg  <= good_cnt_next;
            latch_reg     <= latch_next;
        end
    end

endmodule

`default_nettype wire

### src/cfr_out_buf.sv
`default_nettype none

module cfr_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cfr_pkg::result_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cfr_pkg::result_t       out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    cfr_pkg::result_t out_data_reg;
    cfr_pkg::result_t skid_data_reg;
    logic             in_fire;
    logic             out_fire;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    // valid flags of the output and skid stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= in_fire;
                end
            end
            else if (!out_valid_reg)
            begin
                out_valid_reg <= in_fire;
            end
            else if (in_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload moves
    always_ff @(posedge clk)
    begin
        if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (in_fire && (out_fire || !out_valid_reg))
        begin
            out_data_reg <= in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

### src/checksummed_command_frame_receiver_top.sv
// Command frame receiver with header, tail and 8-bit additive checksum.
// Input stream: one transfer per item. tuser gives the kind (received byte,
// one-millisecond tick, link check), tdata the received byte, tlast marks
// the last byte of a packet. Every input transfer yields exactly one output
// transfer carrying the frame flags, the latched command fields of the last
// good frame, the link state and the good-frame count.
// The first 9-byte window of a packet that opens with 0xAA and closes with
// 0x55 is checked once; the rest of that packet is skipped.
// Results are registered in the output or skid stage. Throughput: one item per
// cycle while s_axis_tready is high; all work sits between the input and the
// output register in a single pass (window shift, 7-byte sum, 32-bit compare).
// An output register plus a one-entry skid stage keep the input open while a
// result waits; if the receiver stalls with both full, s_axis_tready drops
// until the output is taken.
// Reset clears the window, packet state, time, link and count; the link
// timeout register resets to 300 ms; the user must write it through the APB
// port at address 0 only while the stream is idle; the block does not check.
`default_nettype none

module checksummed_command_frame_receiver_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // s_axis_tdata: data_byte
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [cfr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // s_axis_tuser: operation
    input  wire logic [cfr_pkg::IN_USER_W-1:0]      s_axis_tuser,
    input  wire logic                               s_axis_tlast,
    // m_axis_tdata: frame_accepted, checksum_error, mode_switch, gait_switch,
    // velocity_x, velocity_y, turn_rate, body_height, link_active,
    // good_frame_count, zero fill
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [cfr_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [cfr_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    logic [15:0]      timeout_reg;
    logic             in_fire;
    cfr_pkg::item_t   item;
    cfr_pkg::result_t core_result;
    cfr_pkg::result_t out_result;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= cfr_pkg::LINK_TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr == cfr_pkg::ADDR_LINK_TIMEOUT))
        begin
            timeout_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        unique case (paddr)
            cfr_pkg::ADDR_LINK_TIMEOUT: prdata = {16'd0, timeout_reg};
            default:                    prdata = '0;
        endcase
    end

    // input item
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign item.op   = cfr_pkg::op_t'(s_axis_tuser);
    assign item.data = s_axis_tdata;
    assign item.last = s_axis_tlast;

    cfr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_fire),
        .item         (item),
        .link_timeout (timeout_reg),
        .result       (core_result)
    );

    cfr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (core_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = {{(cfr_pkg::OUT_DATA_W - cfr_pkg::RESULT_W){1'b0}}, out_result};

endmodule

`default_nettype wire

### src/cfr_checker.sv
`default_nettype none

module cfr_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [cfr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    cfr_pkg::result_t res;

    assign res = cfr_pkg::result_t'(m_axis_tdata[cfr_pkg::RESULT_W-1:0]);

    // a frame is either good or bad, never both
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res.frame_accepted && res.checksum_error))
        else $error("frame accepted and checksum error together");

    // a good frame always leaves the link active
    a_good_sets_link: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.frame_accepted) |-> res.link_active)
        else $error("good frame without active link");

    // the count is cleared whenever the link is down
    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !res.link_active) |-> (res.good_frame_count == 16'd0))
        else $error("nonzero count while link inactive");

    // a stalled result stays offered
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output dropped while stalled");

endmodule

bind checksummed_command_frame_receiver_top cfr_checker u_cfr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
